// File: design/pebb_pkg.sv
// ============================================================================
// pebb_pkg: shared types and constants for the popularity-evicting buffer
// holds defaults, command codes and the sequencer state type
// ============================================================================
package pebb_pkg;

    localparam int MAX_BLOCKS_DEF  = 64;
    localparam int MAX_FILES_DEF   = 256;
    localparam int MAX_CLIENTS_DEF = 64;
    localparam int SEG_BITS_DEF    = 16;

    localparam int CMD_W      = 2;
    localparam int FILE_W     = 8;
    localparam int SEG_W      = 16;
    localparam int CLIENT_W   = 6;
    localparam int LIMIT_W    = 7;
    localparam int VCOUNT_W   = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK_RD,
        ST_LOOK_CHK,
        ST_EV_RD,
        ST_EV_VRD,
        ST_EV_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_APPEND,
        ST_VIS_RD,
        ST_VIS_WR,
        ST_DONE
    } state_t;

endpackage

// File: design/pebb_entry_mem.sv
// ============================================================================
// pebb_entry_mem: entry store of (file, segment) pairs
// single port, registered read
// ============================================================================
module pebb_entry_mem #(
    parameter int DEPTH = pebb_pkg::MAX_BLOCKS_DEF,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/pebb_visitor_mem.sv
// ============================================================================
// pebb_visitor_mem: per-file visitor bitmap and count
// one read port and one write port, registered read
// ============================================================================
module pebb_visitor_mem #(
    parameter int DEPTH = pebb_pkg::MAX_FILES_DEF,
    parameter int WIDTH = 71
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/popularity_evicting_block_buffer_top.sv
// ============================================================================
// popularity_evicting_block_buffer_top: block buffer with popularity eviction
// sequencer over an entry memory and a visitor memory
// ============================================================================
// channel   dir  handshake          payload
// s_axis    in   tvalid/tready      tdata: command, file_id, seg_id, client_id
// m_axis    out  tvalid/tready      tdata: hit, evicted_valid, file, seg
// cfg       in   cfg_we             cfg_wdata: block_limit
//
// one item at a time; lookup reads and compares held entries in turn until a hit
// insert when full scans every held entry for the least visited file, then shifts
// later entries down and appends; visitor commands read, then write the file's word
// after reset the visitor memory is cleared one file per cycle
// while s_axis_tready stays low
// a result waits in the output register; the next item is taken meanwhile
module popularity_evicting_block_buffer_top #(
    parameter int MAX_BLOCKS  = pebb_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_CLIENTS = pebb_pkg::MAX_CLIENTS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [1:0] command, [9:2] file_id, [25:10] seg_id, [31:26] client_id
    input  logic [pebb_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] hit, [1] evicted_valid, [9:2] evicted_file, [25:10] evicted_seg
    output logic [pebb_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  logic                                  cfg_we,
    input  logic [pebb_pkg::LIMIT_W-1:0]          cfg_wdata
);

    localparam int MAX_FILES = pebb_pkg::MAX_FILES_DEF;
    localparam int SEG_BITS  = pebb_pkg::SEG_BITS_DEF;
    localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int FW  = $clog2(MAX_FILES);
    localparam int EW  = pebb_pkg::FILE_W + SEG_BITS;
    localparam int VW  = MAX_CLIENTS + pebb_pkg::VCOUNT_W;
    localparam int ENTRY_DEPTH = (MAX_BLOCKS > 1) ? MAX_BLOCKS : 2;

    pebb_pkg::state_t state_reg, state_next;

    logic [pebb_pkg::LIMIT_W-1:0]  limit_reg;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 best_reg, best_next;
    logic [pebb_pkg::VCOUNT_W:0]   bestw_reg, bestw_next;
    logic [EW-1:0]                 beste_reg, beste_next;
    logic [EW-1:0]                 cure_reg, cure_next;
    logic [FW-1:0]                 clr_reg, clr_next;
    logic [pebb_pkg::CMD_W-1:0]    cmd_reg;
    logic [pebb_pkg::FILE_W-1:0]   file_reg;
    logic [SEG_BITS-1:0]           seg_reg;
    logic [pebb_pkg::CLIENT_W-1:0] client_reg;
    logic                          hit_reg, hit_next;
    logic                          evv_reg, evv_next;
    logic                          ovalid_reg, ovalid_next;
    logic [pebb_pkg::OUT_DATA_W-1:0] odata_reg, odata_next;

    logic          e_we;
    logic [AW-1:0] e_addr;
    logic [EW-1:0] e_wdata, e_rdata;
    logic          v_we;
    logic [FW-1:0] v_waddr, v_raddr;
    logic [VW-1:0] v_wdata, v_rdata;

    logic [CW-1:0] eff_limit;
    logic          accept;
    logic          client_ok;
    logic [MAX_CLIENTS-1:0]       vbit;
    logic [MAX_CLIENTS-1:0]       vmap;
    logic [pebb_pkg::VCOUNT_W-1:0] vcnt;
    logic [pebb_pkg::VCOUNT_W:0]   vcnt_x;

    pebb_entry_mem #(.DEPTH(ENTRY_DEPTH), .WIDTH(EW)) u_entry (
        .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
    );

    pebb_visitor_mem #(.DEPTH(MAX_FILES), .WIDTH(VW)) u_visitor (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    always_comb
    begin
        if (limit_reg == '0)
            eff_limit = CW'(1);
        else if (32'(limit_reg) > MAX_BLOCKS)
            eff_limit = CW'(MAX_BLOCKS);
        else
            eff_limit = CW'(limit_reg);
    end

    assign s_axis_tready = (state_reg == pebb_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign client_ok     = (32'(client_reg) < MAX_CLIENTS);
    assign vbit          = MAX_CLIENTS'(1) << client_reg;
    assign vmap          = v_rdata[MAX_CLIENTS-1:0];
    assign vcnt          = v_rdata[VW-1:MAX_CLIENTS];
    assign vcnt_x        = {1'b0, vcnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pebb_pkg::ST_CLEAR;
            limit_reg  <= pebb_pkg::LIMIT_RESET;
            count_reg  <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        bestw_reg <= bestw_next;
        beste_reg <= beste_next;
        cure_reg  <= cure_next;
        hit_reg   <= hit_next;
        evv_reg   <= evv_next;
        odata_reg <= odata_next;
        if (accept)
        begin
            cmd_reg    <= s_axis_tdata[1:0];
            file_reg   <= s_axis_tdata[9:2];
            seg_reg    <= s_axis_tdata[10 +: SEG_BITS];
            client_reg <= s_axis_tdata[31:26];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        bestw_next  = bestw_reg;
        beste_next  = beste_reg;
        cure_next   = cure_reg;
        clr_next    = clr_reg;
        hit_next    = hit_reg;
        evv_next    = evv_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        e_we        = 1'b0;
        e_addr      = idx_reg[AW-1:0];
        e_wdata     = {seg_reg, file_reg};
        v_we        = 1'b0;
        v_waddr     = file_reg[FW-1:0];
        v_wdata     = '0;
        v_raddr     = file_reg[FW-1:0];

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            pebb_pkg::ST_CLEAR:
            begin
                v_we    = 1'b1;
                v_waddr = clr_reg;
                clr_next = clr_reg + FW'(1);
                if (32'(clr_reg) == MAX_FILES - 1)
                    state_next = pebb_pkg::ST_IDLE;
            end
            pebb_pkg::ST_IDLE:
            begin
                idx_next   = '0;
                hit_next   = 1'b0;
                evv_next   = 1'b0;
                best_next  = '0;
                bestw_next = '1;
                if (accept)
                begin
                    case (s_axis_tdata[1:0])
                        pebb_pkg::CMD_LOOKUP: state_next = pebb_pkg::ST_LOOK_RD;
                        pebb_pkg::CMD_INSERT:
                        begin
                            if (count_reg >= eff_limit && count_reg != '0)
                                state_next = pebb_pkg::ST_EV_RD;
                            else
                                state_next = pebb_pkg::ST_APPEND;
                        end
                        default: state_next = pebb_pkg::ST_VIS_RD;
                    endcase
                end
            end
            pebb_pkg::ST_LOOK_RD:
            begin
                if (idx_reg >= count_reg || hit_reg)
                    state_next = pebb_pkg::ST_DONE;
                else
                    state_next = pebb_pkg::ST_LOOK_CHK;
            end
            pebb_pkg::ST_LOOK_CHK:
            begin
                if (e_rdata == {seg_reg, file_reg})
                    hit_next = 1'b1;
                idx_next   = idx_reg + CW'(1);
                e_addr     = idx_next[AW-1:0];
                state_next = pebb_pkg::ST_LOOK_RD;
            end
            pebb_pkg::ST_EV_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    evv_next   = 1'b1;
                    idx_next   = best_reg;
                    e_addr     = best_reg[AW-1:0];
                    state_next = pebb_pkg::ST_SH_RD;
                end
                else
                    state_next = pebb_pkg::ST_EV_VRD;
            end
            pebb_pkg::ST_EV_VRD:
            begin
                cure_next  = e_rdata;
                v_raddr    = e_rdata[FW-1:0];
                state_next = pebb_pkg::ST_EV_CHK;
            end
            pebb_pkg::ST_EV_CHK:
            begin
                // strict compare keeps the oldest of equal counts
                if (vcnt_x < bestw_reg)
                begin
                    bestw_next = vcnt_x;
                    best_next  = idx_reg;
                    beste_next = cure_reg;
                end
                idx_next   = idx_reg + CW'(1);
                e_addr     = idx_next[AW-1:0];
                state_next = pebb_pkg::ST_EV_RD;
            end
            pebb_pkg::ST_SH_RD:
            begin
                // close the gap: read entry idx+1
                if (idx_reg + CW'(1) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = pebb_pkg::ST_APPEND;
                end
                else
                begin
                    e_addr     = idx_reg[AW-1:0] + AW'(1);
                    state_next = pebb_pkg::ST_SH_WR;
                end
            end
            pebb_pkg::ST_SH_WR:
            begin
                e_we       = 1'b1;
                e_addr     = idx_reg[AW-1:0];
                e_wdata    = e_rdata;
                idx_next   = idx_reg + CW'(1);
                state_next = pebb_pkg::ST_SH_RD;
            end
            pebb_pkg::ST_APPEND:
            begin
                if (32'(count_reg) < MAX_BLOCKS)
                begin
                    e_we       = 1'b1;
                    e_addr     = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
                state_next = pebb_pkg::ST_DONE;
            end
            pebb_pkg::ST_VIS_RD:
            begin
                state_next = pebb_pkg::ST_VIS_WR;
            end
            pebb_pkg::ST_VIS_WR:
            begin
                if (client_ok)
                begin
                    if (cmd_reg == pebb_pkg::CMD_ADD && (vmap & vbit) == '0)
                    begin
                        v_we    = 1'b1;
                        v_wdata = {vcnt + pebb_pkg::VCOUNT_W'(1), vmap | vbit};
                    end
                    else if (cmd_reg == pebb_pkg::CMD_REMOVE && (vmap & vbit) != '0)
                    begin
                        v_we    = 1'b1;
                        v_wdata = {vcnt - pebb_pkg::VCOUNT_W'(1), vmap & ~vbit};
                    end
                end
                state_next = pebb_pkg::ST_DONE;
            end
            pebb_pkg::ST_DONE:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = '0;
                    odata_next[0] = hit_reg;
                    odata_next[1] = evv_reg;
                    if (evv_reg)
                    begin
                        odata_next[9:2] = beste_reg[pebb_pkg::FILE_W-1:0];
                        odata_next[10 +: SEG_BITS] = beste_reg[EW-1:pebb_pkg::FILE_W];
                    end
                    state_next = pebb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pebb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/pebb_checker.sv
// ============================================================================
// pebb_checker: port-level checks on the block buffer
// watches the stream ports over time
// ============================================================================
module pebb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result holds its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a transfer in blocks the next one in the following cycle
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken twice in a row");

    // hit and eviction never appear together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("hit and eviction both set");

    // no eviction means zero file and segment
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[25:2] == '0)
        else $error("eviction fields not zero");

endmodule

bind popularity_evicting_block_buffer_top pebb_checker u_pebb_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// File: bench/popularity_evicting_block_buffer_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// popularity_evicting_block_buffer_top_test: buffer command stream check
// drives lookup, insert and visitor commands over several block limits and
// compares every result with an internal model of the buffer
// ============================================================================
module popularity_evicting_block_buffer_top_test;

    typedef struct packed {
        logic [15:0] seg;
        logic [7:0]  file;
        logic        ev_valid;
        logic        hit;
    } result_t;

    class buffer_scoreboard;
        logic [7:0]  ent_file [64];
        logic [15:0] ent_seg  [64];
        int          n_ent;
        logic [63:0] vmap [256];
        int          vcnt [256];
        int          limit;
        result_t     pending [$];
        int          errors;

        function void clear();
            n_ent = 0;
            limit = 64;
            errors = 0;
            for (int f = 0; f < 256; f++)
            begin
                vmap[f] = '0;
                vcnt[f] = 0;
            end
        endfunction

        function void set_limit(logic [6:0] v);
            limit = (v == 0) ? 1 : ((v > 64) ? 64 : int'(v));
        endfunction

        function void note_item(logic [1:0] cmd, logic [7:0] f, logic [15:0] s,
                                logic [5:0] c);
            result_t r;
            int best;
            int best_w;
            r = '0;
            case (cmd)
                pebb_pkg::CMD_LOOKUP:
                    for (int i = 0; i < n_ent; i++)
                        if (ent_file[i] == f && ent_seg[i] == s) r.hit = 1'b1;
                pebb_pkg::CMD_INSERT:
                begin
                    if (n_ent >= limit && n_ent > 0)
                    begin
                        best = 0;
                        best_w = 1 << 30;
                        for (int i = 0; i < n_ent; i++)
                            if (vcnt[ent_file[i]] < best_w)
                            begin
                                best_w = vcnt[ent_file[i]];
                                best = i;
                            end
                        r.ev_valid = 1'b1;
                        r.file = ent_file[best];
                        r.seg = ent_seg[best];
                        for (int i = best; i < n_ent - 1; i++)
                        begin
                            ent_file[i] = ent_file[i+1];
                            ent_seg[i] = ent_seg[i+1];
                        end
                        n_ent--;
                    end
                    if (n_ent < 64)
                    begin
                        ent_file[n_ent] = f;
                        ent_seg[n_ent] = s;
                        n_ent++;
                    end
                end
                pebb_pkg::CMD_ADD:
                    if (!vmap[f][c])
                    begin
                        vmap[f][c] = 1'b1;
                        vcnt[f]++;
                    end
                default:
                    if (vmap[f][c])
                    begin
                        vmap[f][c] = 1'b0;
                        vcnt[f]--;
                    end
            endcase
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.hit !== exp.hit)
            begin
                $display("%0t: hit exp %b got %b", $time, exp.hit, got.hit);
                errors++;
            end
            if (got.ev_valid !== exp.ev_valid)
            begin
                $display("%0t: evicted_valid exp %b got %b", $time, exp.ev_valid,
                         got.ev_valid);
                errors++;
            end
            if (got.file !== exp.file)
            begin
                $display("%0t: evicted_file exp %h got %h", $time, exp.file, got.file);
                errors++;
            end
            if (got.seg !== exp.seg)
            begin
                $display("%0t: evicted_seg exp %h got %h", $time, exp.seg, got.seg);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;

    buffer_scoreboard sb;
    bit quiet_sender;
    bit quiet_receiver;
    bit hold_receiver;
    logic [7:0] hot_files [4];

    popularity_evicting_block_buffer_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // tvalid stays up after a transfer until the next idle cycle or a stop
    task automatic send_item(logic [1:0] cmd, logic [7:0] f, logic [15:0] s,
                             logic [5:0] c);
        while (!quiet_sender && $urandom_range(99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c, s, f, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(cmd, f, s, c);
    endtask

    // let the buffer drain before touching the limit register
    task automatic write_limit(logic [6:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(v);
    endtask

    task automatic random_phase(int n);
        logic [1:0] cmd;
        logic [7:0] f;
        for (int k = 0; k < n; k++)
        begin
            cmd = 2'($urandom_range(3));
            // mostly a small file set so hits and visitor ties are common
            if ($urandom_range(9) < 8) f = hot_files[2'($urandom_range(3))];
            else f = 8'($urandom);
            if ($urandom_range(3) == 0)
                send_item(cmd, f, 16'($urandom), 6'($urandom));
            else
                send_item(cmd, f,
                          16'($urandom_range(7)) | {1'($urandom_range(1)), 15'd0},
                          6'($urandom_range(7)) | {1'($urandom_range(1)), 5'd0});
        end
    endtask

    // receiver
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(result_t'(m_axis_tdata[25:0]));
            m_axis_tready <= !hold_receiver &&
                             (quiet_receiver || $urandom_range(99) >= 19);
        end
    end

    initial
    begin
        #60000000;
        $display("popularity_evicting_block_buffer_top test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        hold_receiver = 1'b0;
        hot_files[0] = 8'h00;
        hot_files[1] = 8'hFF;
        hot_files[2] = 8'h5A;
        hot_files[3] = 8'hA5;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: tiny limit, extremes, visitor edge cases
        write_limit(7'd0);
        send_item(pebb_pkg::CMD_LOOKUP, 8'h00, 16'h0000, 6'd0);
        send_item(pebb_pkg::CMD_INSERT, 8'hFF, 16'hFFFF, 6'd63);
        send_item(pebb_pkg::CMD_LOOKUP, 8'hFF, 16'hFFFF, 6'd0);
        send_item(pebb_pkg::CMD_INSERT, 8'h00, 16'h0000, 6'd0);
        send_item(pebb_pkg::CMD_ADD, 8'h00, 16'hFFFF, 6'd63);
        send_item(pebb_pkg::CMD_ADD, 8'h00, 16'h0000, 6'd63);
        send_item(pebb_pkg::CMD_ADD, 8'hFF, 16'h0000, 6'd0);
        send_item(pebb_pkg::CMD_REMOVE, 8'hFF, 16'h0000, 6'd1);
        send_item(pebb_pkg::CMD_REMOVE, 8'hFF, 16'h0000, 6'd0);
        write_limit(7'd3);
        send_item(pebb_pkg::CMD_INSERT, 8'h01, 16'h0001, 6'd0);
        send_item(pebb_pkg::CMD_INSERT, 8'h02, 16'h0002, 6'd0);
        send_item(pebb_pkg::CMD_ADD, 8'h01, 16'h0, 6'd5);
        send_item(pebb_pkg::CMD_INSERT, 8'h03, 16'h0003, 6'd0);
        send_item(pebb_pkg::CMD_INSERT, 8'h01, 16'h0001, 6'd0);
        send_item(pebb_pkg::CMD_LOOKUP, 8'h01, 16'h0001, 6'd0);
        // limit lowered below the count
        write_limit(7'd1);
        send_item(pebb_pkg::CMD_INSERT, 8'h04, 16'h0004, 6'd0);
        send_item(pebb_pkg::CMD_LOOKUP, 8'h04, 16'h0004, 6'd0);
        write_limit(7'd127);

        // send items while the receiver holds off
        fork
            begin
                hold_receiver = 1'b1;
                repeat (3000) @(posedge clk);
                hold_receiver = 1'b0;
            end
            random_phase(40);
        join
        quiet_sender = 1'b1;
        quiet_receiver = 1'b1;
        random_phase(150);
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        random_phase(150);
        write_limit(7'd1);
        random_phase(150);
        write_limit(7'd64);
        random_phase(200);
        write_limit(7'd8);
        random_phase(200);
        write_limit(7'($urandom_range(65, 127)));
        random_phase(160);
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0)
            $display("popularity_evicting_block_buffer_top test passed");
        else
            $display("popularity_evicting_block_buffer_top test failed");
        $finish;
    end
endmodule

// File: sim.f
design/pebb_pkg.sv
design/pebb_entry_mem.sv
design/pebb_visitor_mem.sv
design/popularity_evicting_block_buffer_top.sv
design/pebb_checker.sv
bench/popularity_evicting_block_buffer_top_test.sv
